@@ hdl/assert_macros.svh @@
// Assertion macros used by the deque top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deque assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deque assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/deq_pkg.sv @@
// Shared types and codes for the deque block.
`timescale 1ns / 1ps
package deq_pkg;

    typedef logic signed [31:0] word_t;

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_READ       = 2'd2;
    localparam logic [1:0] CMD_SEARCH     = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam word_t EMPTY_WORD = -32'sd1;

    typedef struct packed {
        logic load;
        logic shift;
        logic rotate;
    } cell_ctrl_t;

endpackage

@@ hdl/deque_with_index_read_and_search_top.sv @@
// Top level of the bounded deque with indexed read and search.
// Push front / push back: the result word is registered in the cycle after accept.
// Read and search: the walk rotates the cell chain once, each cell passing cell 0.
// Throughput: one push per cycle unless the result is stalled; a walk blocks input.
// Reset: asynchronous, clears size and control registers; cell contents are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module deque_with_index_read_and_search_top
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  word_t       value,
    input  logic [3:0]  position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output word_t       read_value,
    output logic [3:0]  found_position,
    output logic [4:0]  size,
    output logic        is_empty,
    output word_t       front_value,
    output word_t       back_value
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (CW > 5) ? CW : 5;
    localparam int FW = (IW > 4) ? IW : 4;
    localparam int PW = (CW > 4) ? CW : 4;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   step_reg, step_next;
    logic [1:0]      cmd_reg, cmd_next;
    word_t           val_reg, val_next;
    logic [3:0]      pos_reg, pos_next;
    logic            hit_reg, hit_next;
    logic [IW-1:0]   fpos_reg, fpos_next;
    word_t           rd_acc_reg, rd_acc_next;
    word_t           front_reg, front_next;
    word_t           back_reg, back_next;

    logic            out_valid_reg, out_valid_next;
    logic [1:0]      status_reg, status_next;
    word_t           read_value_reg, read_value_next;
    logic [3:0]      found_reg, found_next;
    logic [4:0]      size_reg, size_next;
    logic            empty_reg, empty_next;
    word_t           front_out_reg, front_out_next;
    word_t           back_out_reg, back_out_next;

    logic            shift_en, load_en, rotate_en;
    logic            accept, full, last_step, emit;
    logic            pos_ok, read_hit, match_now;
    logic [1:0]      emit_status;
    word_t           emit_rd;
    logic [IW-1:0]   emit_found;
    logic [FW-1:0]   found_wide;
    logic [SW-1:0]   size_wide;
    word_t           cell_data [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_ctrl_t ctrl;
            word_t      prev_d;
            word_t      next_d;
            assign ctrl.load   = load_en && (count_reg == CW'(gi));
            assign ctrl.shift  = shift_en;
            assign ctrl.rotate = rotate_en;
            if (gi == 0)
            begin : g_first
                assign prev_d = value;
            end
            else
            begin : g_mid
                assign prev_d = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign next_d = cell_data[0];
            end
            else
            begin : g_inner
                assign next_d = cell_data[gi+1];
            end
            deq_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .prev_data (prev_d),
                .next_data (next_d),
                .load_data (value),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign last_step = (step_reg == IW'(DEPTH - 1));
    assign pos_ok    = (PW'(pos_reg) < PW'(count_reg));
    assign read_hit  = (PW'(step_reg) == PW'(pos_reg));
    assign match_now = !hit_reg && (CW'(step_reg) < count_reg) && (cell_data[0] == val_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        fpos_next       = fpos_reg;
        rd_acc_next     = rd_acc_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        found_next      = found_reg;
        size_next       = size_reg;
        empty_next      = empty_reg;
        front_out_next  = front_out_reg;
        back_out_next   = back_out_reg;
        shift_en        = 1'b0;
        load_en         = 1'b0;
        rotate_en       = 1'b0;
        emit            = 1'b0;
        emit_status     = ST_OK;
        emit_rd         = '0;
        emit_found      = '0;
        found_wide      = '0;
        size_wide       = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                emit_status = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                if (command == CMD_PUSH_FRONT)
                                begin
                                    shift_en   = 1'b1;
                                    front_next = value;
                                    if (count_reg == '0)
                                    begin
                                        back_next = value;
                                    end
                                end
                                else
                                begin
                                    load_en   = 1'b1;
                                    back_next = value;
                                    if (count_reg == '0)
                                    begin
                                        front_next = value;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            state_next  = S_WALK;
                            step_next   = '0;
                            cmd_next    = command;
                            val_next    = value;
                            pos_next    = position;
                            hit_next    = 1'b0;
                            fpos_next   = '0;
                            rd_acc_next = '0;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                rotate_en = 1'b1;
                step_next = step_reg + IW'(1);
                if (cmd_reg == CMD_READ)
                begin
                    if (read_hit)
                    begin
                        rd_acc_next = cell_data[0];
                    end
                end
                else if (match_now)
                begin
                    hit_next  = 1'b1;
                    fpos_next = step_reg;
                end
                if (last_step)
                begin
                    state_next = S_IDLE;
                    emit       = 1'b1;
                    if (cmd_reg == CMD_READ)
                    begin
                        emit_status = pos_ok ? ST_OK : ST_BADPOS;
                        if (pos_ok)
                        begin
                            emit_rd = read_hit ? cell_data[0] : rd_acc_reg;
                        end
                    end
                    else
                    begin
                        emit_status = (hit_reg || match_now) ? ST_OK : ST_NOTFOUND;
                        emit_found  = match_now ? step_reg : fpos_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            found_wide      = FW'(emit_found);
            size_wide       = SW'(count_next);
            out_valid_next  = 1'b1;
            status_next     = emit_status;
            read_value_next = emit_rd;
            found_next      = found_wide[3:0];
            size_next       = size_wide[4:0];
            empty_next      = (count_next == '0);
            front_out_next  = (count_next == '0) ? EMPTY_WORD : front_next;
            back_out_next   = (count_next == '0) ? EMPTY_WORD : back_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            cmd_reg        <= '0;
            val_reg        <= '0;
            pos_reg        <= '0;
            fpos_reg       <= '0;
            rd_acc_reg     <= '0;
            front_reg      <= '0;
            back_reg       <= '0;
            status_reg     <= '0;
            read_value_reg <= '0;
            found_reg      <= '0;
            size_reg       <= '0;
            empty_reg      <= 1'b0;
            front_out_reg  <= '0;
            back_out_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
            cmd_reg        <= cmd_next;
            val_reg        <= val_next;
            pos_reg        <= pos_next;
            fpos_reg       <= fpos_next;
            rd_acc_reg     <= rd_acc_next;
            front_reg      <= front_next;
            back_reg       <= back_next;
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            found_reg      <= found_next;
            size_reg       <= size_next;
            empty_reg      <= empty_next;
            front_out_reg  <= front_out_next;
            back_out_reg   <= back_out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign read_value     = read_value_reg;
    assign found_position = found_reg;
    assign size           = size_reg;
    assign is_empty       = empty_reg;
    assign front_value    = front_out_reg;
    assign back_value     = back_out_reg;

    `ASSERT_IMPLIES(a_walk_blocks_input, clk, rst_n, state_reg == S_WALK, !in_ready)
    `ASSERT_NEXT(a_count_holds, clk, rst_n, !accept, $stable(count_reg))
    `ASSERT_NEXT(a_walk_ends_in_word, clk, rst_n, state_reg == S_WALK && last_step, out_valid)
    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, out_valid, count_reg <= CW'(DEPTH) && is_empty == (size == 5'd0))

endmodule

@@ hdl/deq_cell.sv @@
// One storage cell of the deque chain.
`timescale 1ns / 1ps
module deq_cell
    import deq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  word_t      prev_data,
    input  word_t      next_data,
    input  word_t      load_data,
    output word_t      data
);

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = prev_data;
        end
        else if (ctrl.rotate)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ sim/tb_deque_with_index_read_and_search_top.sv @@
// Self-checking testbench for the bounded deque with indexed read and search.
`timescale 1ns / 1ps
module tb_deque_with_index_read_and_search_top
    import deq_pkg::*;
();

    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 1725;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct {
        logic [1:0] status;
        word_t      read_value;
        logic [3:0] found_position;
        logic [4:0] size;
        logic       is_empty;
        word_t      front_value;
        word_t      back_value;
    } deque_result_t;

    class deque_scoreboard;
        word_t         shadow_cells[DEPTH];
        int            head_slot;
        int            live_count;
        deque_result_t awaited_results[$];
        int            errors;
        int            results_seen;
        int            status_hits[4];
        int            command_hits[4];

        function new();
            head_slot  = 0;
            live_count = 0;
        endfunction

        function int slot(int offset);
            return (head_slot + offset) % DEPTH;
        endfunction

        function word_t live_word(int offset);
            return shadow_cells[slot(offset)];
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function deque_result_t apply_command(logic [1:0] cmd, word_t val, logic [3:0] pos);
            deque_result_t r;
            bit            hit;
            r.status         = ST_OK;
            r.read_value     = '0;
            r.found_position = '0;
            hit              = 1'b0;
            case (cmd)
                CMD_PUSH_FRONT:
                begin
                    if (live_count >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        head_slot = slot(DEPTH - 1);
                        shadow_cells[head_slot] = val;
                        live_count++;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (live_count >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        shadow_cells[slot(live_count)] = val;
                        live_count++;
                    end
                end
                CMD_READ:
                begin
                    if (int'(pos) < live_count)
                        r.read_value = shadow_cells[slot(int'(pos))];
                    else
                        r.status = ST_BADPOS;
                end
                default:
                begin
                    r.status = ST_NOTFOUND;
                    for (int i = 0; i < live_count && !hit; i++)
                    begin
                        if (shadow_cells[slot(i)] == val)
                        begin
                            hit              = 1'b1;
                            r.status         = ST_OK;
                            r.found_position = i[3:0];
                        end
                    end
                end
            endcase
            r.size     = live_count[4:0];
            r.is_empty = (live_count == 0);
            if (live_count == 0)
            begin
                r.front_value = EMPTY_WORD;
                r.back_value  = EMPTY_WORD;
            end
            else
            begin
                r.front_value = shadow_cells[slot(0)];
                r.back_value  = shadow_cells[slot(live_count - 1)];
            end
            return r;
        endfunction

        function void note_command(logic [1:0] cmd, word_t val, logic [3:0] pos);
            command_hits[cmd]++;
            awaited_results.push_back(apply_command(cmd, val, pos));
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
        endtask

        task check_result(deque_result_t got);
            deque_result_t want;
            if (awaited_results.size() == 0)
            begin
                report("result word with no command pending");
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("read_value", got.read_value, want.read_value);
            compare_field("found_position", got.found_position, want.found_position);
            compare_field("size", got.size, want.size);
            compare_field("is_empty", got.is_empty, want.is_empty);
            compare_field("front_value", got.front_value, want.front_value);
            compare_field("back_value", got.back_value, want.back_value);
            status_hits[want.status]++;
            results_seen++;
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    word_t      value;
    logic [3:0] position;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    word_t      read_value;
    logic [3:0] found_position;
    logic [4:0] size;
    logic       is_empty;
    word_t      front_value;
    word_t      back_value;

    deque_scoreboard sb;
    bit              calm_stretch;
    int              cycle_count;

    deque_with_index_read_and_search_top #(.DEPTH(DEPTH)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .value          (value),
        .position       (position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .size           (size),
        .is_empty       (is_empty),
        .front_value    (front_value),
        .back_value     (back_value)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_stretch || roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return EMPTY_WORD;
            3:       return '0;
            4, 5:    return word_t'($urandom_range(0, 7));
            default: return word_t'($urandom);
        endcase
    endfunction

    task send_word(input logic [1:0] cmd, input word_t val, input logic [3:0] pos);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        position <= pos;
        do @(posedge clk); while (!in_ready);
        sb.note_command(cmd, val, pos);
    endtask

    task drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // result side: bursts of ready broken by stalls
    initial
    begin
        int hold;
        int stall;
        hold = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                stall = pick_gap();
                if (stall > 0 && out_ready)
                begin
                    out_ready <= 1'b0;
                    hold = stall - 1;
                end
                else
                begin
                    out_ready <= 1'b1;
                    hold = $urandom_range(0, 8);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        deque_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.status         = status;
            got.read_value     = read_value;
            got.found_position = found_position;
            got.size           = size;
            got.is_empty       = is_empty;
            got.front_value    = front_value;
            got.back_value     = back_value;
            sb.check_result(got);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [1:0] cmd;
        word_t      val;
        int         roll;
        sb           = new();
        calm_stretch = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        command  <= CMD_PUSH_FRONT;
        value    <= '0;
        position <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store
        send_word(CMD_SEARCH, '0, 4'd0);
        send_word(CMD_READ, '0, 4'd0);
        send_word(CMD_READ, '0, 4'd15);
        // front pointer wraps on the first front push
        send_word(CMD_PUSH_BACK, 32'sh7fff_ffff, 4'd0);
        send_word(CMD_PUSH_FRONT, 32'sh8000_0000, 4'd0);
        send_word(CMD_PUSH_FRONT, EMPTY_WORD, 4'd0);
        send_word(CMD_PUSH_BACK, 32'sd5, 4'd0);
        send_word(CMD_PUSH_BACK, 32'sd5, 4'd0);
        send_word(CMD_PUSH_BACK, 32'sd0, 4'd0);
        send_word(CMD_SEARCH, 32'sd5, 4'd0);
        send_word(CMD_SEARCH, 32'sd0, 4'd0);
        send_word(CMD_SEARCH, EMPTY_WORD, 4'd0);
        send_word(CMD_SEARCH, 32'sd123456, 4'd0);
        send_word(CMD_READ, '0, 4'd5);
        send_word(CMD_READ, '0, 4'd6);
        // fill to capacity, then refused pushes at both ends
        for (int i = 0; i < DEPTH - 6; i++)
            send_word(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                      i[1] ? 32'sh5555_5555 : 32'shaaaa_aaaa, 4'd0);
        send_word(CMD_PUSH_BACK, 32'sd9, 4'd0);
        send_word(CMD_PUSH_FRONT, 32'sd9, 4'd0);
        send_word(CMD_READ, '0, 4'd15);
        send_word(CMD_SEARCH, sb.live_word(DEPTH - 1), 4'd0);

        drain_results();
        // the store only grows, so restart the shadow contents via pushes is not possible;
        // random traffic exercises reads and searches on a full ring with random pushes
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 150 == 0)
                calm_stretch = ($urandom_range(0, 2) == 0);
            if (n == 400 || n == 1100)
                drain_results();
            roll = $urandom_range(0, 99);
            val  = pick_word();
            if (roll < 20)
                cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else if (roll < 55)
                cmd = CMD_READ;
            else
            begin
                cmd = CMD_SEARCH;
                if (sb.live_count > 0 && $urandom_range(0, 9) < 7)
                    val = sb.live_word($urandom_range(0, sb.live_count - 1));
            end
            send_word(cmd, val, 4'($urandom_range(0, 15)));
        end

        drain_results();
        repeat (DEPTH + 8) @(posedge clk);
        $display("Covered %0d push-front, %0d push-back, %0d read, %0d search words; %0d results",
                 sb.command_hits[CMD_PUSH_FRONT], sb.command_hits[CMD_PUSH_BACK],
                 sb.command_hits[CMD_READ], sb.command_hits[CMD_SEARCH], sb.results_seen);
        $display("Statuses seen: ok %0d, full %0d, bad position %0d, not found %0d; errors %0d",
                 sb.status_hits[ST_OK], sb.status_hits[ST_FULL],
                 sb.status_hits[ST_BADPOS], sb.status_hits[ST_NOTFOUND], sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
